[sv/mrmc_pkg.sv]
// ----------------------------------------------------------------------------
// Memory region map carver package
// Shared types, constants and codes for the region table carver.
// ----------------------------------------------------------------------------
package mrmc_pkg;

    localparam int MAX_REGIONS = 64;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int N_W         = IDX_W + 2;
    localparam int ADDR_W      = IDX_W + 1;
    localparam int WIDE_BIT    = 31;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_RESERVE = 2'd1,
        OP_ALIGN   = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_WIDE    = 3'd1,
        ST_OVERLAP = 3'd2,
        ST_FULL    = 3'd3,
        ST_BAD_IDX = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        CFG_AVAILABLE = 1'b0,
        CFG_RESERVED  = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        WS_COPY,
        WS_LO,
        WS_HI,
        WS_NEW,
        WS_ALIGN
    } t_wsel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_RD,
        S_RD_EV,
        S_CK_RD,
        S_CK_EV,
        S_AP_RD,
        S_AP_EV,
        S_AP_HI,
        S_AP_NEW,
        S_AL_RD,
        S_AL_EV,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op         command;
        logic [31:0] region_base;
        logic [31:0] region_size;
        logic [7:0]  region_type;
        logic [31:0] align_bytes;
        logic [5:0]  entry_index;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [31:0] entry_base;
        logic [31:0] entry_size;
        logic [7:0]  entry_type;
        logic [6:0]  entry_count;
    } t_out;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] size;
        logic [7:0]  rtype;
    } t_entry;

    typedef struct packed {
        logic    cap;
        logic    clr_i;
        logic    inc_i;
        logic    clr_n;
        logic    inc_n;
        logic    rd;
        logic    rd_idx;
        logic    wr;
        t_wsel   wsel;
        logic    commit;
        logic    set_fault;
        logic    st_we;
        t_status st;
        logic    data_ok;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic fault;
        logic wide;
        logic empty;
        logic i_end;
        logic idx_bad;
        logic ovl;
        logic bad_type;
        logic lo;
        logic hi;
        logic al_ok;
        logic n_full;
        logic out_busy;
    } t_sts;

endpackage

[sv/mrmc_ctrl.sv]
// ----------------------------------------------------------------------------
// Memory region map carver controller
// Sequences the check, carve, align and read passes over the region table.
// ----------------------------------------------------------------------------
module mrmc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  mrmc_pkg::t_sts i_sts,
    output mrmc_pkg::t_cmd o_cmd
);
    import mrmc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.wsel = WS_COPY;
        o_cmd.st   = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.clr_i = 1'b1;
                o_cmd.clr_n = 1'b1;
                o_cmd.st_we = 1'b1;
                if (i_sts.op == OP_READ) begin
                    n_state = S_RD;
                end else if (i_sts.fault) begin
                    o_cmd.st = ST_OVERLAP;
                    n_state  = S_DONE;
                end else if (i_sts.op == OP_ALIGN) begin
                    n_state = S_AL_RD;
                end else if (i_sts.wide) begin
                    o_cmd.st = ST_WIDE;
                    n_state  = S_DONE;
                end else if (i_sts.empty) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CK_RD;
                end
            end
            S_RD: begin
                if (i_sts.idx_bad) begin
                    o_cmd.st_we = 1'b1;
                    o_cmd.st    = ST_BAD_IDX;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_idx = 1'b1;
                    n_state      = S_RD_EV;
                end
            end
            S_RD_EV: begin
                o_cmd.st_we   = 1'b1;
                o_cmd.st      = i_sts.fault ? ST_OVERLAP : ST_OK;
                o_cmd.data_ok = 1'b1;
                n_state       = S_DONE;
            end
            S_CK_RD: begin
                if (i_sts.i_end) begin
                    o_cmd.clr_i = 1'b1;
                    n_state     = S_AP_RD;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CK_EV;
                end
            end
            S_CK_EV: begin
                if (i_sts.ovl && i_sts.bad_type) begin
                    o_cmd.set_fault = 1'b1;
                    o_cmd.st_we     = 1'b1;
                    o_cmd.st        = ST_OVERLAP;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.inc_i = 1'b1;
                    n_state     = S_CK_RD;
                end
            end
            S_AP_RD: begin
                if (i_sts.i_end) begin
                    n_state = S_AP_NEW;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_AP_EV;
                end
            end
            S_AP_EV: begin
                n_state = S_AP_RD;
                if (!i_sts.ovl) begin
                    o_cmd.wr    = 1'b1;
                    o_cmd.wsel  = WS_COPY;
                    o_cmd.inc_n = 1'b1;
                    o_cmd.inc_i = 1'b1;
                end else if (i_sts.lo) begin
                    o_cmd.wr    = 1'b1;
                    o_cmd.wsel  = WS_LO;
                    o_cmd.inc_n = 1'b1;
                    if (i_sts.hi) begin
                        n_state = S_AP_HI;
                    end else begin
                        o_cmd.inc_i = 1'b1;
                    end
                end else if (i_sts.hi) begin
                    o_cmd.wr    = 1'b1;
                    o_cmd.wsel  = WS_HI;
                    o_cmd.inc_n = 1'b1;
                    o_cmd.inc_i = 1'b1;
                end else begin
                    o_cmd.inc_i = 1'b1;
                end
            end
            S_AP_HI: begin
                o_cmd.wr    = 1'b1;
                o_cmd.wsel  = WS_HI;
                o_cmd.inc_n = 1'b1;
                o_cmd.inc_i = 1'b1;
                n_state     = S_AP_RD;
            end
            S_AP_NEW: begin
                o_cmd.st_we = 1'b1;
                n_state     = S_DONE;
                if (i_sts.n_full) begin
                    o_cmd.st = ST_FULL;
                end else begin
                    o_cmd.wr     = 1'b1;
                    o_cmd.wsel   = WS_NEW;
                    o_cmd.commit = 1'b1;
                end
            end
            S_AL_RD: begin
                if (i_sts.i_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_AL_EV;
                end
            end
            S_AL_EV: begin
                o_cmd.wr    = i_sts.al_ok;
                o_cmd.wsel  = WS_ALIGN;
                o_cmd.inc_i = 1'b1;
                n_state     = S_AL_RD;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/mrmc_dp.sv]
// ----------------------------------------------------------------------------
// Memory region map carver datapath
// Double-banked region table, scan counters, carve arithmetic and result
// register.
// ----------------------------------------------------------------------------
module mrmc_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mrmc_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mrmc_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    input  logic [0:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data,
    input  mrmc_pkg::t_cmd i_cmd,
    output mrmc_pkg::t_sts o_sts
);
    import mrmc_pkg::*;

    t_entry r_mem [2*MAX_REGIONS];
    t_entry r_rdata;

    logic [7:0]       r_avail;
    logic [7:0]       r_resv;
    logic             r_fault;
    logic             r_bank;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_i;
    logic [N_W-1:0]   r_n;
    t_in              r_req;
    t_status          r_status;
    logic             r_data_ok;
    logic             r_out_valid;
    t_out             r_out;

    logic [32:0]      w_ne;
    logic [32:0]      w_eb;
    logic [32:0]      w_ee;
    logic [32:0]      w_nb;
    logic [32:0]      w_m;
    logic [32:0]      w_al;
    logic [7:0]       w_nt;
    logic             w_ovl;
    logic [ADDR_W-1:0] w_raddr;
    logic [ADDR_W-1:0] w_waddr;
    logic             w_wen;
    t_entry           w_wdata;

    assign w_nb = {1'b0, r_req.region_base};
    assign w_ne = w_nb + {1'b0, r_req.region_size};
    assign w_eb = {1'b0, r_rdata.base};
    assign w_ee = w_eb + {1'b0, r_rdata.size};
    assign w_m  = (r_req.align_bytes == 32'd0) ? 33'd0 : ({1'b0, r_req.align_bytes} - 33'd1);
    assign w_al = (w_eb + w_m) & ~w_m;
    assign w_nt = (r_req.command == OP_ADD) ? r_req.region_type : r_resv;

    assign w_ovl = (r_req.region_size != 32'd0) && (r_rdata.size != 32'd0)
                   && (w_nb < w_ee) && (w_ne > w_eb);

    always_comb begin
        o_sts.op       = r_req.command;
        o_sts.fault    = r_fault;
        o_sts.wide     = r_req.region_base[WIDE_BIT] || r_req.region_size[WIDE_BIT];
        o_sts.empty    = (r_req.region_size == 32'd0);
        o_sts.i_end    = (r_i == r_count);
        o_sts.idx_bad  = (32'(r_req.entry_index) >= 32'(r_count));
        o_sts.ovl      = w_ovl;
        o_sts.bad_type = (r_rdata.rtype != r_avail) || (r_rdata.rtype == w_nt);
        o_sts.lo       = (w_nb > w_eb);
        o_sts.hi       = (w_ne < w_ee);
        o_sts.al_ok    = (r_rdata.rtype == r_avail) && (w_al > w_eb) && (w_al < w_ee);
        o_sts.n_full   = (32'(r_n) >= MAX_REGIONS);
        o_sts.out_busy = r_out_valid && i_out_stall;
    end

    assign w_raddr = i_cmd.rd_idx ? {r_bank, r_req.entry_index[IDX_W-1:0]}
                                  : {r_bank, r_i[IDX_W-1:0]};

    always_comb begin
        w_wdata = r_rdata;
        w_waddr = {~r_bank, r_n[IDX_W-1:0]};
        w_wen   = i_cmd.wr && (32'(r_n) < MAX_REGIONS);
        case (i_cmd.wsel)
            WS_COPY: begin
                w_wdata = r_rdata;
            end
            WS_LO: begin
                w_wdata.size = 32'(w_nb - w_eb);
            end
            WS_HI: begin
                w_wdata.base = w_ne[31:0];
                w_wdata.size = 32'(w_ee - w_ne);
            end
            WS_NEW: begin
                w_wdata.base  = r_req.region_base;
                w_wdata.size  = r_req.region_size;
                w_wdata.rtype = w_nt;
            end
            WS_ALIGN: begin
                w_wdata.base = w_al[31:0];
                w_wdata.size = 32'(w_ee - w_al);
                w_waddr      = {r_bank, r_i[IDX_W-1:0]};
                w_wen        = i_cmd.wr;
            end
            default: begin
                w_wdata = r_rdata;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[w_raddr];
        end
        if (i_cmd.cap) begin
            r_req <= i_in_data;
        end
        if (i_cmd.st_we) begin
            r_status <= i_cmd.st;
        end
        if (i_cmd.out_load) begin
            r_out.status      <= r_status;
            r_out.entry_base  <= r_data_ok ? r_rdata.base : 32'd0;
            r_out.entry_size  <= r_data_ok ? r_rdata.size : 32'd0;
            r_out.entry_type  <= r_data_ok ? r_rdata.rtype : 8'd0;
            r_out.entry_count <= 7'(r_count);
        end
        if (i_cmd.clr_i) begin
            r_i <= '0;
        end else if (i_cmd.inc_i) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.clr_n) begin
            r_n <= '0;
        end else if (i_cmd.inc_n) begin
            r_n <= r_n + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail     <= 8'd1;
            r_resv      <= 8'd2;
            r_fault     <= 1'b0;
            r_bank      <= 1'b0;
            r_count     <= '0;
            r_data_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_AVAILABLE) begin
                    r_avail <= i_cfg_data;
                end else begin
                    r_resv <= i_cfg_data;
                end
            end
            if (i_cmd.set_fault) begin
                r_fault <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_bank  <= ~r_bank;
                r_count <= CNT_W'(r_n + 1'b1);
            end
            if (i_cmd.cap) begin
                r_data_ok <= 1'b0;
            end else if (i_cmd.data_ok) begin
                r_data_ok <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[sv/memory_region_map_carver.sv]
// ----------------------------------------------------------------------------
// Memory region map carver
// Region table with add, reserve, align and read commands.
// ----------------------------------------------------------------------------
// Commands arrive on the input channel as one beat each and every command
// returns exactly one result beat. Both channels use valid and stall.
// Registers for the available and reserved type codes are written on the
// configuration channel, which is always ready; write them only while idle.
// A read checks the index and, if it is in range, reads the entry; its
// result then goes to the output register. Add and reserve run a check pass
// and then a carve pass over the table, one entry at a time in each pass,
// with an extra step for every split. Align runs one pass over the table.
// Commands rejected up front go straight to the result. The block returns
// to idle after each command before the next beat is accepted. The table
// memory is read and then written one entry at a time.
// A new command is taken once the previous one has its result placed in
// the output register; a stalled result holds there while the next command
// runs, and the block waits to deliver until the output register frees.
// Reset empties the table, clears the fault flag and restores the type
// codes to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module memory_region_map_carver (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mrmc_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mrmc_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [0:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data
);
    import mrmc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    mrmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mrmc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

[sv/mrmc_checker.sv]
// ----------------------------------------------------------------------------
// Memory region map carver checker
// Port-level properties of the carver, bound to the top level.
// ----------------------------------------------------------------------------
module mrmc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input mrmc_pkg::t_out o_out_data
);
    import mrmc_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("carver accepted a beat without going busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    a_bad_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_BAD_IDX |->
            o_out_data.entry_base == 32'd0 && o_out_data.entry_size == 32'd0
            && o_out_data.entry_type == 8'd0)
        else $error("bad index read returned data");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_data.entry_count) <= MAX_REGIONS)
        else $error("entry count beyond table size");

endmodule

bind memory_region_map_carver mrmc_checker u_mrmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Region table carver testbench
// Drives add, reserve, align and read commands into the carver, predicts each
// result beat from a local copy of the region table and checks every field.
// Idling and stalling vary by phase, with one long output hold-off, and the
// type code registers change between phases. A sticky fault is raised last.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrmc_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       o_in_stall;
    t_in        in_data = '0;
    logic       o_out_valid;
    logic       out_stall = 1'b0;
    t_out       o_out_data;
    logic       cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [0:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    memory_region_map_carver u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    logic [31:0] tbl_base [MAX_REGIONS];
    logic [31:0] tbl_size [MAX_REGIONS];
    logic [7:0]  tbl_type [MAX_REGIONS];
    int          tbl_cnt = 0;
    bit          fault_sticky = 1'b0;
    logic [7:0]  avail_code = 8'd1;
    logic [7:0]  rsvd_code = 8'd2;

    t_in  cmd_q [$];
    t_out result_q [$];
    int   n_push = 0;
    int   n_acc = 0;
    int   err_cnt = 0;
    int   send_idle = 0;
    int   recv_stall = 0;
    bit   long_hold = 1'b0;

    function automatic t_status carve(logic [31:0] nb32, logic [31:0] ns32,
                                      logic [7:0] nt, bit dry);
        logic [63:0] nb, ns, ne, eb, ee;
        logic [31:0] pb [2*MAX_REGIONS+1];
        logic [31:0] ps [2*MAX_REGIONS+1];
        logic [7:0]  pt [2*MAX_REGIONS+1];
        int          n;
        bit          hit;
        nb = {32'd0, nb32};
        ns = {32'd0, ns32};
        ne = nb + ns;
        n  = 0;
        if (nb32[WIDE_BIT] || ns32[WIDE_BIT]) return ST_WIDE;
        for (int i = 0; i < tbl_cnt; i++) begin
            eb  = {32'd0, tbl_base[i]};
            ee  = eb + {32'd0, tbl_size[i]};
            hit = ns != 0 && eb < ee && nb < ee && ne > eb;
            if (hit && (tbl_type[i] != avail_code || tbl_type[i] == nt)) begin
                if (!dry) fault_sticky = 1'b1;
                return ST_OVERLAP;
            end
        end
        for (int i = 0; i < tbl_cnt; i++) begin
            eb  = {32'd0, tbl_base[i]};
            ee  = eb + {32'd0, tbl_size[i]};
            hit = ns != 0 && eb < ee && nb < ee && ne > eb;
            if (!hit) begin
                pb[n] = tbl_base[i]; ps[n] = tbl_size[i]; pt[n] = tbl_type[i]; n++;
            end else begin
                if (nb > eb) begin
                    pb[n] = eb[31:0]; ps[n] = nb[31:0] - eb[31:0]; pt[n] = tbl_type[i]; n++;
                end
                if (ne < ee) begin
                    pb[n] = ne[31:0]; ps[n] = ee[31:0] - ne[31:0]; pt[n] = tbl_type[i]; n++;
                end
            end
        end
        if (ns != 0) begin
            pb[n] = nb32; ps[n] = ns32; pt[n] = nt; n++;
        end
        if (n > MAX_REGIONS) return ST_FULL;
        if (!dry) begin
            for (int i = 0; i < n; i++) begin
                tbl_base[i] = pb[i]; tbl_size[i] = ps[i]; tbl_type[i] = pt[i];
            end
            tbl_cnt = n;
        end
        return ST_OK;
    endfunction

    function automatic void align_available(logic [31:0] a32);
        logic [63:0] a, m, b, e, al;
        a = (a32 == 0) ? 64'd1 : {32'd0, a32};
        m = a - 1;
        for (int i = 0; i < tbl_cnt; i++) begin
            if (tbl_type[i] == avail_code) begin
                b  = {32'd0, tbl_base[i]};
                e  = b + {32'd0, tbl_size[i]};
                al = (b + m) & ~m;
                if (al > b && al < e) begin
                    tbl_base[i] = al[31:0];
                    tbl_size[i] = e[31:0] - al[31:0];
                end
            end
        end
    endfunction

    function automatic t_out predict_result(t_in it);
        t_out r;
        r = '0;
        r.status = ST_OK;
        if (it.command == OP_READ) begin
            if (int'(it.entry_index) >= tbl_cnt) begin
                r.status = ST_BAD_IDX;
            end else begin
                r.status     = fault_sticky ? ST_OVERLAP : ST_OK;
                r.entry_base = tbl_base[it.entry_index];
                r.entry_size = tbl_size[it.entry_index];
                r.entry_type = tbl_type[it.entry_index];
            end
        end else if (fault_sticky) begin
            r.status = ST_OVERLAP;
        end else begin
            case (it.command)
                OP_ADD:     r.status = carve(it.region_base, it.region_size,
                                             it.region_type, 1'b0);
                OP_RESERVE: r.status = carve(it.region_base, it.region_size,
                                             rsvd_code, 1'b0);
                default:    align_available(it.align_bytes);
            endcase
        end
        r.entry_count = 7'(tbl_cnt);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: result %0d %s mismatch: got %h, expected %h",
                 $realtime, n_acc, field, got, want);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                result_q.push_back(predict_result(in_data));
                n_acc++;
            end
            if (!in_valid || !o_in_stall) begin
                if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    in_data  <= cmd_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $realtime);
                    err_cnt++;
                end else begin
                    want = result_q.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", 32'(o_out_data.status), 32'(want.status));
                    if (o_out_data.entry_base !== want.entry_base)
                        report_mismatch("entry_base", o_out_data.entry_base, want.entry_base);
                    if (o_out_data.entry_size !== want.entry_size)
                        report_mismatch("entry_size", o_out_data.entry_size, want.entry_size);
                    if (o_out_data.entry_type !== want.entry_type)
                        report_mismatch("entry_type", 32'(o_out_data.entry_type),
                                        32'(want.entry_type));
                    if (o_out_data.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(o_out_data.entry_count),
                                        32'(want.entry_count));
                end
            end
            out_stall <= long_hold || ($urandom_range(99) < recv_stall);
        end
    end

    // Long output hold-off so the block fills and stalls its input.
    initial begin
        wait (n_acc >= 300);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (800) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin
        #60ms;
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic send_cmd(t_in it);
        cmd_q.push_back(it);
        n_push++;
        wait (n_acc == n_push);
    endtask

    function automatic t_in make_cmd(t_op op, logic [31:0] b, logic [31:0] s,
                                     logic [7:0] t, logic [31:0] a, logic [5:0] idx);
        t_in it;
        it.command = op; it.region_base = b; it.region_size = s;
        it.region_type = t; it.align_bytes = a; it.entry_index = idx;
        return it;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [7:0] val);
        wait (n_acc == n_push && result_q.size() == 0);
        repeat (10) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!(cfg_valid && o_cfg_ready));
        if (idx == CFG_AVAILABLE) avail_code = val;
        else rsvd_code = val;
        cfg_valid <= 1'b0;
    endtask

    function automatic t_in random_cmd(logic [31:0] win);
        t_in it;
        int  r;
        it.command     = t_op'($urandom_range(3));
        it.region_base = $urandom();
        it.region_size = $urandom();
        it.region_type = 8'($urandom());
        it.align_bytes = $urandom();
        it.entry_index = 6'($urandom());
        r = $urandom_range(99);
        if (r < 35) begin
            it.command = OP_READ;
            if ($urandom_range(3) != 0) it.entry_index = 6'($urandom_range(tbl_cnt));
        end else if (r < 45) begin
            it.command = OP_ALIGN;
            if ($urandom_range(7) != 0) it.align_bytes = 32'd1 << $urandom_range(31);
            else if ($urandom_range(1) == 0) it.align_bytes = 32'd0;
        end else if (r < 50) begin
            it.command = $urandom_range(1) ? OP_ADD : OP_RESERVE;
            if ($urandom_range(2) == 0) it.region_size = 32'd0;
        end else begin
            for (int k = 0; k < 8; k++) begin
                it.command     = $urandom_range(3) == 0 ? OP_RESERVE : OP_ADD;
                it.region_base = win + ($urandom_range(32'h3FFF) & 32'hFFFF_FFF0);
                it.region_size = $urandom_range(32'h1000, 1);
                it.region_type = $urandom_range(1) ? avail_code : 8'($urandom());
                if (carve(it.region_base, it.region_size,
                          it.command == OP_RESERVE ? rsvd_code : it.region_type,
                          1'b1) != ST_OVERLAP) return it;
            end
            it.command = OP_READ;
        end
        return it;
    endfunction

    initial begin
        int idle_tab [4][2] = '{'{0, 0}, '{66, 0}, '{0, 66}, '{29, 29}};
        int cfg_tab [6][2] = '{'{1, 2}, '{0, 255}, '{255, 0}, '{1, 2}, '{9, 9}, '{1, 2}};
        logic [31:0] win;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_ALIGN, 0, 0, 0, 32'h1000, 0));
        send_cmd(make_cmd(OP_ADD, 32'h100, 0, 1, 0, 0));
        send_cmd(make_cmd(OP_ADD, 32'h8000_0000, 32'h10, 1, 0, 0));
        send_cmd(make_cmd(OP_RESERVE, 32'h10, 32'hFFFF_FFFF, 0, 0, 0));
        send_cmd(make_cmd(OP_ADD, 32'h1000, 32'h1000, 1, 0, 0));
        send_cmd(make_cmd(OP_RESERVE, 32'h0F00, 32'h200, 0, 0, 0));
        send_cmd(make_cmd(OP_RESERVE, 32'h1E00, 32'h400, 0, 0, 0));
        send_cmd(make_cmd(OP_ADD, 32'h1400, 32'h100, 8'hFF, 0, 0));
        send_cmd(make_cmd(OP_ADD, 32'h3000, 32'h100, 1, 0, 0));
        send_cmd(make_cmd(OP_RESERVE, 32'h2F00, 32'h300, 0, 0, 0));
        send_cmd(make_cmd(OP_ADD, 32'h1200, 32'h10, 8'hFE, 0, 0));
        send_cmd(make_cmd(OP_ALIGN, 0, 0, 0, 32'h1000, 0));
        send_cmd(make_cmd(OP_ALIGN, 0, 0, 0, 32'd0, 0));
        send_cmd(make_cmd(OP_ALIGN, 0, 0, 0, 32'd3, 0));
        send_cmd(make_cmd(OP_ALIGN, 0, 0, 0, 32'h8000_0000, 0));
        for (int i = 0; i < 8; i++) send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 6'(i)));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 6'd63));

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_AVAILABLE, 8'(cfg_tab[ph][0]));
            write_reg(CFG_RESERVED, 8'(cfg_tab[ph][1]));
            send_idle  = idle_tab[ph % 4][0];
            recv_stall = idle_tab[ph % 4][1];
            win = 32'(ph) << 24;
            if (ph == 2) begin
                for (int i = 0; i < MAX_REGIONS + 2; i++)
                    send_cmd(make_cmd(OP_ADD, win + 32'(i) * 32'h100, 32'h80,
                                      avail_code, 0, 0));
            end
            for (int i = 0; i < 200; i++) send_cmd(random_cmd(win + 32'h0080_0000));
        end

        if (tbl_cnt == 0) send_cmd(make_cmd(OP_ADD, 32'h10, 32'h10, avail_code, 0, 0));
        send_cmd(make_cmd(OP_ADD, tbl_base[0], 32'd1, avail_code, 0, 0));
        send_cmd(make_cmd(OP_RESERVE, 32'h4000_0000, 32'h10, 0, 0, 0));
        send_cmd(make_cmd(OP_ADD, 32'h8000_0000, 32'h10, 1, 0, 0));
        send_cmd(make_cmd(OP_ALIGN, 0, 0, 0, 32'h10, 0));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 6'd0));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 6'd63));

        wait (cmd_q.size() == 0 && n_acc == n_push && result_q.size() == 0);
        repeat (400) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
